FILE: hdl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
// Field widths, configuration register codes and reset values.
// No dependencies.
package mexp_pkg;

  // Fixed width of the message, result and key fields
  localparam int unsigned FieldW = 64;

  // Configuration register index
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_EXPONENT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS  = 1'b1;

  // Key values after reset
  localparam logic [FieldW-1:0] ExpReset = 64'd65537;
  localparam logic [FieldW-1:0] ModReset = 64'd1;

endpackage

FILE: hdl/mexp_mulmod.sv
// Bit-serial modular multiplier: prod = (a * b) mod m, one bit of b per cycle.
// Interleaved reduction keeps the accumulator below m after every step.
// Depends on nothing but its parameter; done_o pulses once the last bit of b has been processed.
module mexp_mulmod #(
  parameter int unsigned WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] a_q;
  logic [WIDTH-1:0] b_q;

  // One step: acc = (2*acc + bit*a) mod m, with the sum below 3m
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m_one;
  logic [WIDTH+1:0] m_two;
  logic [WIDTH+1:0] step;

  always_comb begin
    sum   = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[WIDTH-1] ? a_q : '0)};
    m_one = {2'b00, m_i};
    m_two = {1'b0, m_i, 1'b0};
    if (sum >= m_two) begin
      step = sum - m_two;
    end else if (sum >= m_one) begin
      step = sum - m_one;
    end else begin
      step = sum;
    end
  end

  // Sequence the bits of b, most significant first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntLast;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = step[WIDTH-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and accumulator registers; shift b left each step
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      b_q <= {b_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: hdl/modular_exponentiation.sv
// One transaction at a time. The time from accept to result valid grows with the number of
// set exponent bits, with the position of the highest one and with any output stall; a zero
// exponent goes straight from the base reduction to the result. The next transaction is
// accepted in the same cycle that the result shows, as input ready rises with output valid.
// The shared bit-serial multiplier sets the pace: it does the base reduction and every
// multiply or square in turn. Reset: asynchronous, active low; exponent returns to 65537,
// modulus to 1, no result held.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [FieldW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FieldW-1:0]  message_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [FieldW-1:0]  result_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_NEXT   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_SQR    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [WIDTH-1:0] exp_q;
  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] e_q, e_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic [WIDTH-1:0] base_q, base_d;
  logic             out_valid_q, out_valid_d;
  logic [FieldW-1:0] result_q, result_d;

  logic             in_accept;
  logic             mm_start;
  logic [WIDTH-1:0] mm_a;
  logic [WIDTH-1:0] mm_b;
  logic [WIDTH-1:0] m_eff;
  logic             mm_done;
  logic [WIDTH-1:0] mm_prod;

  // Zero modulus acts as one
  assign m_eff     = (mod_q == '0) ? WIDTH'(1) : mod_q;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept = in_valid_i && in_ready_o;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= ExpReset[WIDTH-1:0];
      mod_q <= ModReset[WIDTH-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EXPONENT: exp_q <= cfg_data_i[WIDTH-1:0];
        CFG_MODULUS:  mod_q <= cfg_data_i[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Sequence: reduce base, then scan exponent bits low to high
  always_comb begin
    state_d     = state_q;
    e_d         = e_q;
    res_d       = res_q;
    base_d      = base_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    mm_start    = 1'b0;
    mm_a        = base_q;
    mm_b        = base_q;

    // Drop the held result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          e_d      = exp_q;
          res_d    = WIDTH'(1);
          mm_start = 1'b1;
          mm_a     = WIDTH'(1);
          mm_b     = message_i[WIDTH-1:0];
          state_d  = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          base_d  = mm_prod;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (e_q == '0) begin
          state_d = S_DONE;
        end else if (e_q[0]) begin
          mm_start = 1'b1;
          mm_a     = res_q;
          mm_b     = base_q;
          state_d  = S_MUL;
        end else begin
          mm_start = 1'b1;
          e_d      = e_q >> 1;
          state_d  = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          res_d   = mm_prod;
          e_d     = {e_q[WIDTH-1:1], 1'b0};
          state_d = S_NEXT;
        end
      end
      S_SQR: begin
        if (mm_done) begin
          base_d  = mm_prod;
          state_d = S_NEXT;
        end
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          result_d    = FieldW'(res_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q      <= e_d;
    res_q    <= res_d;
    base_q   <= base_d;
    result_q <= result_d;
  end

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (m_eff),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: hdl/mexp_checker.sv
// Port-level checks for modular_exponentiation, attached by bind.
// Depends on mexp_pkg for field widths.
module mexp_checker
  import mexp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [FieldW-1:0] result_o
);

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_o))
    else $error("result changed or dropped while stalled");

  // One transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  // No result right after a transaction enters
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

  // A new result comes only from a busy block
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_o    (result_o)
);
